FILE: hw/rtl/tilt_complementary_filter_core_assert.svh
// Assertion macros for the tilt filter core
`ifndef TILT_COMPLEMENTARY_FILTER_CORE_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_CORE_ASSERT_SVH

// Implication check, reset is active low
`define TCF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check
`define TCF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, constants and the CORDIC angle table of the tilt filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int CordicSteps = 20;
    localparam int StepW       = $clog2(CordicSteps + 1);
    localparam int QDepth      = 2;

    localparam logic signed [25:0] AngleLimit = 26'sd23592960;
    localparam logic signed [24:0] HalfTurn   = 25'sd11796480;

    localparam logic [1:0] RegGyroGain = 2'd0;
    localparam logic [1:0] RegTimeStep = 2'd1;
    localparam logic [1:0] RegBlend    = 2'd2;

    typedef struct packed {
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
        logic signed [15:0] gyro_x;
    } t_sample;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_CORDIC,
        S_DELTA,
        S_MIX,
        S_DONE
    } t_state;

    function automatic logic [21:0] atan_lut(input logic [4:0] idx);
        case (idx)
            5'd0:  atan_lut = 22'd2949120;
            5'd1:  atan_lut = 22'd1740967;
            5'd2:  atan_lut = 22'd919879;
            5'd3:  atan_lut = 22'd466945;
            5'd4:  atan_lut = 22'd234379;
            5'd5:  atan_lut = 22'd117304;
            5'd6:  atan_lut = 22'd58666;
            5'd7:  atan_lut = 22'd29335;
            5'd8:  atan_lut = 22'd14668;
            5'd9:  atan_lut = 22'd7334;
            5'd10: atan_lut = 22'd3667;
            5'd11: atan_lut = 22'd1833;
            5'd12: atan_lut = 22'd917;
            5'd13: atan_lut = 22'd458;
            5'd14: atan_lut = 22'd229;
            5'd15: atan_lut = 22'd115;
            5'd16: atan_lut = 22'd57;
            5'd17: atan_lut = 22'd29;
            5'd18: atan_lut = 22'd14;
            5'd19: atan_lut = 22'd7;
            5'd20: atan_lut = 22'd4;
            5'd21: atan_lut = 22'd2;
            5'd22: atan_lut = 22'd1;
            default: atan_lut = 22'd0;
        endcase
    endfunction

endpackage

FILE: hw/rtl/tcf_front.sv
// ----------------------------------------------------------------------------
// tcf_front
// Input stage and sample queue: accepts samples and buffers them for the core.
// ----------------------------------------------------------------------------
module tcf_front import tcf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_acc_y,
    input  logic signed [15:0] i_acc_z,
    input  logic signed [15:0] i_gyro_x,
    output logic               o_q_valid,
    input  logic               i_q_pop,
    output t_sample            o_q_data
);

    t_sample          r_mem [QDepth];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;

    assign o_stall   = (r_cnt == 2'(QDepth));
    assign w_push    = i_valid && !o_stall;
    assign w_pop     = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{acc_y: i_acc_y, acc_z: i_acc_z, gyro_x: i_gyro_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    `include "tilt_complementary_filter_core_assert.svh"
    `TCF_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_cnt == 2'(QDepth), !w_push, "queue overflow")
    `TCF_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 2'(QDepth), "count out of range")
    `TCF_ASSERT_NXT(a_pop_only, i_clk, i_rst_n, w_pop && !w_push, r_cnt == $past(r_cnt) - 2'd1, "pop miscount")

endmodule

FILE: hw/rtl/tcf_back.sv
// ----------------------------------------------------------------------------
// tcf_back
// Compute sequencer: gyro scaling, iterative CORDIC atan2, and angle fusion.
// ----------------------------------------------------------------------------
module tcf_back import tcf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  t_sample            i_q_data,
    input  logic [15:0]        i_gyro_gain,
    input  logic [15:0]        i_time_step,
    input  logic [16:0]        i_blend,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [25:0] o_filtered_angle,
    output logic signed [31:0] o_gyro_rate,
    output logic signed [24:0] o_acc_angle
);

    t_state r_state, n_state;
    t_sample r_smp;
    logic [StepW-1:0]   r_step;
    logic signed [32:0] r_x, r_y;
    logic signed [26:0] r_ang;
    logic signed [31:0] r_rate;
    logic signed [24:0] r_acc;
    logic signed [31:0] r_delta;
    logic signed [35:0] r_new;
    logic signed [25:0] r_fused;
    logic               r_zero;
    logic               r_ovalid;

    logic               w_take, w_out, w_post;
    logic signed [32:0] w_dx, w_dy;
    logic signed [22:0] w_at;
    logic signed [49:0] w_dprod;
    logic signed [17:0] w_w, w_wc;
    logic signed [32:0] w_sum;
    logic signed [51:0] w_mix;
    logic signed [35:0] w_new;
    logic signed [26:0] w_angc;

    assign w_out  = r_ovalid && !i_stall;
    assign w_take = (r_state == S_IDLE) && i_q_valid;
    // post only once the output register is free
    assign w_post = (r_state == S_DONE) && (!r_ovalid || w_out);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_q_valid) n_state = S_RATE;
            S_RATE:   n_state = S_CORDIC;
            S_CORDIC: if (r_step == StepW'(CordicSteps - 1)) n_state = S_DELTA;
            S_DELTA:  n_state = S_MIX;
            S_MIX:    n_state = S_DONE;
            S_DONE:   if (w_post) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = w_take;
    end

    assign w_dx    = r_y >>> r_step;
    assign w_dy    = r_x >>> r_step;
    assign w_at    = $signed({1'b0, atan_lut(5'(r_step))});
    assign w_dprod = r_rate * $signed({1'b0, i_time_step}) + 50'sd32768;
    assign w_w     = (i_blend > 17'd65536) ? 18'sd65536 : $signed({1'b0, i_blend});
    assign w_wc    = 18'sd65536 - w_w;
    assign w_sum   = 33'(r_fused) + r_delta;
    assign w_mix   = w_w * w_sum + w_wc * r_acc + 52'sd32768;
    assign w_new   = 36'(w_mix >>> 16);
    assign w_angc  = (r_ang > 27'(HalfTurn)) ? 27'(HalfTurn) :
                     (r_ang < -27'(HalfTurn)) ? -27'(HalfTurn) : r_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fused  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_post) begin
                r_fused  <= (r_new > 36'(AngleLimit)) ? AngleLimit :
                            (r_new < -36'(AngleLimit)) ? -AngleLimit : 26'(r_new);
                r_ovalid <= 1'b1;
            end else if (w_out) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_smp <= i_q_data;
            end
            S_RATE: begin
                r_rate <= r_smp.gyro_x * $signed({1'b0, i_gyro_gain});
                r_step <= '0;
                r_zero <= (r_smp.acc_y == 16'sd0) && (r_smp.acc_z == 16'sd0);
                if (r_smp.acc_z < 0) begin
                    r_x   <= -(33'(r_smp.acc_z) <<< 14);
                    r_y   <= -(33'(r_smp.acc_y) <<< 14);
                    r_ang <= (r_smp.acc_y >= 0) ? 27'(HalfTurn) : -27'(HalfTurn);
                end else begin
                    r_x   <= 33'(r_smp.acc_z) <<< 14;
                    r_y   <= 33'(r_smp.acc_y) <<< 14;
                    r_ang <= '0;
                end
            end
            S_CORDIC: begin
                // rotate toward the x axis
                if (r_y < 0) begin
                    r_x   <= r_x - w_dx;
                    r_y   <= r_y + w_dy;
                    r_ang <= r_ang - 27'(w_at);
                end else begin
                    r_x   <= r_x + w_dx;
                    r_y   <= r_y - w_dy;
                    r_ang <= r_ang + 27'(w_at);
                end
                r_step <= r_step + 1'b1;
            end
            S_DELTA: begin
                r_delta <= 32'(w_dprod >>> 16);
                r_acc   <= r_zero ? 25'sd0 : 25'(w_angc);
            end
            S_MIX: begin
                r_new <= w_new;
            end
            S_DONE: begin
                if (w_post) begin
                    o_gyro_rate <= r_rate;
                    o_acc_angle <= r_acc;
                end
            end
            default: ;
        endcase
    end

    assign o_valid          = r_ovalid;
    assign o_filtered_angle = r_fused;

    `include "tilt_complementary_filter_core_assert.svh"
    `TCF_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_q_pop, r_state == S_IDLE, "pop outside idle")
    `TCF_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_ovalid && i_stall, r_ovalid && $stable(r_fused), "result lost")
    `TCF_ASSERT_IMP(a_fused_lim, i_clk, i_rst_n, 1'b1, r_fused <= AngleLimit && r_fused >= -AngleLimit, "angle past limit")

endmodule

FILE: hw/rtl/tilt_complementary_filter_core.sv
// ----------------------------------------------------------------------------
// tilt_complementary_filter_core
// Accelerometer/gyro roll fusion with an iterative CORDIC atan2.
// ----------------------------------------------------------------------------
// Usage: present one IMU sample (acc_y, acc_z, gyro_x) on the input channel
// with i_valid; the beat is taken when o_stall is low. A two-entry queue
// takes samples while the back end computes. Each sample yields one result
// beat (filtered_angle, gyro_rate, acc_angle) with o_valid; it holds until
// i_stall is low. From an idle block the back end dequeues the sample, runs
// the gyro multiply, 20 CORDIC iterations (one per cycle in a single
// shift-add unit), the time-step product and the blend, then posts the
// result. It takes the next sample only after posting the last one. A
// stalled result holds the back end; the queue still absorbs two samples
// before o_stall rises. Reset (synchronous, active low) clears the kept
// angle to zero, empties the queue and loads gyro_gain 500, time_step 721
// and blend_weight 64225. Write registers only while idle.
// ----------------------------------------------------------------------------
module tilt_complementary_filter_core import tcf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_acc_y,
    input  logic signed [15:0] i_acc_z,
    input  logic signed [15:0] i_gyro_x,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [25:0] o_filtered_angle,
    output logic signed [31:0] o_gyro_rate,
    output logic signed [24:0] o_acc_angle,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [16:0]        i_cfg_data
);

    logic [15:0] r_gain, r_tstep;
    logic [16:0] r_blend;
    logic        w_qv, w_pop;
    t_sample     w_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= 16'd500;
            r_tstep <= 16'd721;
            r_blend <= 17'd64225;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegGyroGain: r_gain  <= i_cfg_data[15:0];
                RegTimeStep: r_tstep <= i_cfg_data[15:0];
                RegBlend:    r_blend <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcf_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_acc_y, .i_acc_z, .i_gyro_x,
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_data(w_qd)
    );

    tcf_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_qv), .o_q_pop(w_pop), .i_q_data(w_qd),
        .i_gyro_gain(r_gain), .i_time_step(r_tstep), .i_blend(r_blend),
        .o_valid, .i_stall, .o_filtered_angle, .o_gyro_rate, .o_acc_angle
    );

endmodule
